// ===== sv/priority_message_scheduler_assert.svh =====
// Assertion macros used by the scheduler datapath.
// Each macro is compiled away when ASSERT_OFF is defined.
`ifndef PRIORITY_MESSAGE_SCHEDULER_ASSERT_SVH
`define PRIORITY_MESSAGE_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under reset.
`define PMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication under reset.
`define PMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define PMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/pms_pkg.sv =====
package pms_pkg;

  // Default sizing of the scheduler.
  localparam int DEF_PRIORITY_LEVELS = 8;
  localparam int DEF_QUEUE_DEPTH     = 8;
  localparam int DEF_TASK_SLOTS      = 16;

  // Message word: task id over signal.
  localparam int TID_W = 4;
  localparam int SIG_W = 8;
  localparam int MSG_W = TID_W + SIG_W;

  // Request codes.
  localparam logic [1:0] REQ_POST     = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TASK = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRIORITY_MAP = 2'd0;
  localparam logic [1:0] CFG_TASK_COUNT   = 2'd1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_DREAD,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic exec;
    logic remove_step;
    logic capture;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_remove;
    logic go_read;
    logic remove_done;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/pms_ram.sv =====
module pms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/pms_ctrl.sv =====
module pms_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pms_pkg::sts_t sts,
  output pms_pkg::cmd_t cmd
);

  pms_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pms_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      pms_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
        if (in_valid) begin
          state_nxt = pms_pkg::S_EXEC;
        end
      end
      pms_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.go_remove) begin
          state_nxt = pms_pkg::S_REMOVE;
        end else if (sts.go_read) begin
          state_nxt = pms_pkg::S_DREAD;
        end else begin
          state_nxt = pms_pkg::S_EMIT;
        end
      end
      pms_pkg::S_REMOVE: begin
        cmd.remove_step = 1'b1;
        if (sts.remove_done) begin
          state_nxt = pms_pkg::S_EMIT;
        end
      end
      pms_pkg::S_DREAD: begin
        cmd.capture = 1'b1;
        state_nxt   = pms_pkg::S_EMIT;
      end
      pms_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = pms_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pms_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pms_datapath.sv =====
`include "priority_message_scheduler_assert.svh"

module pms_datapath #(
  parameter int PRIORITY_LEVELS = pms_pkg::DEF_PRIORITY_LEVELS,
  parameter int QUEUE_DEPTH     = pms_pkg::DEF_QUEUE_DEPTH,
  parameter int TASK_SLOTS      = pms_pkg::DEF_TASK_SLOTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_req_type,
  input  logic [3:0]    in_task_id,
  input  logic [7:0]    in_sig,
  input  logic [3:0]    in_threshold,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data,
  input  pms_pkg::cmd_t cmd,
  output pms_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [3:0]    out_task_id,
  output logic [7:0]    out_sig,
  output logic [3:0]    out_priority,
  output logic [3:0]    out_removed_count,
  output logic [7:0]    out_ready_mask
);

  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = FW + 1;
  localparam int PLW   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int DEPTH = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Circular position of entry pos behind the head.
  function automatic logic [HW-1:0] slot_of(logic [HW-1:0] head, logic [FW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return HW'(sum);
  endfunction

  // Memory address of a slot in a level's region.
  function automatic logic [AW-1:0] addr_of(logic [PLW-1:0] lvl, logic [HW-1:0] s);
    return AW'(int'(lvl) * QUEUE_DEPTH + int'(s));
  endfunction

  // Request and configuration registers.
  logic [1:0]  req_type_r;
  logic [3:0]  task_id_r;
  logic [7:0]  sig_r;
  logic [3:0]  thr_r;
  logic [47:0] map_r;
  logic [4:0]  count_r;

  // Queue state.
  logic [HW-1:0] head_r [PRIORITY_LEVELS];
  logic [FW-1:0] fill_r [PRIORITY_LEVELS];

  // Working registers of the current request.
  logic [PLW-1:0] lvl_r;
  logic [FW-1:0]  rd_r, wr_r, removed_r;
  logic           pend_r;
  logic [1:0]     status_r;
  logic [3:0]     res_tid_r, res_pri_r;
  logic [7:0]     res_sig_r;

  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [3:0]     out_task_id_r, out_priority_r, out_removed_r;
  logic [7:0]     out_sig_r, out_ready_r;

  // Memory ports.
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [pms_pkg::MSG_W-1:0] mem_wdata, mem_rdata;

  // Task lookup.
  logic [2:0]     map_lvl;
  logic [4:0]     cnt_eff;
  logic           task_ok;
  logic [PLW-1:0] req_lvl;

  assign map_lvl = map_r[3*task_id_r +: 3];
  assign cnt_eff = (count_r > 5'(TASK_SLOTS)) ? 5'(TASK_SLOTS) : count_r;
  assign task_ok = ({1'b0, task_id_r} < cnt_eff) &&
                   ({1'b0, map_lvl} < 4'(PRIORITY_LEVELS));
  assign req_lvl = PLW'(map_lvl);

  // Highest non-empty level and the ready mask.
  logic           top_found;
  logic [PLW-1:0] top_lvl;
  logic [7:0]     ready_mask_c;

  always_comb begin
    top_found    = 1'b0;
    top_lvl      = '0;
    ready_mask_c = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (fill_r[i] != '0) begin
        top_found       = 1'b1;
        top_lvl         = PLW'(i);
        ready_mask_c[i] = 1'b1;
      end
    end
  end

  // Outcome of the request in the execute step.
  logic       post_ok, go_remove, go_read, disp_ok;
  logic [1:0] exec_status;

  assign disp_ok = top_found && ((5'(top_lvl) + 5'd1) > {1'b0, thr_r});

  always_comb begin
    post_ok     = 1'b0;
    go_remove   = 1'b0;
    go_read     = 1'b0;
    exec_status = pms_pkg::ST_OK;
    unique case (req_type_r)
      pms_pkg::REQ_POST: begin
        priority if (!task_ok) begin
          exec_status = pms_pkg::ST_BAD_TASK;
        end else if (fill_r[req_lvl] == FW'(QUEUE_DEPTH)) begin
          exec_status = pms_pkg::ST_FULL;
        end else begin
          post_ok = 1'b1;
        end
      end
      pms_pkg::REQ_REMOVE: begin
        if (!task_ok) begin
          exec_status = pms_pkg::ST_BAD_TASK;
        end else begin
          go_remove = 1'b1;
        end
      end
      pms_pkg::REQ_DISPATCH: begin
        if (!disp_ok) begin
          exec_status = pms_pkg::ST_NONE;
        end else begin
          go_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Remove walk: issue reads ahead, compact survivors behind them.
  logic rm_issue, rm_match, rm_keep, rm_done;

  assign rm_issue = rd_r < fill_r[lvl_r];
  assign rm_match = (mem_rdata == {task_id_r, sig_r});
  assign rm_keep  = cmd.remove_step && pend_r && !rm_match;
  assign rm_done  = !rm_issue && !pend_r;

  // Memory address and data selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(lvl_r, slot_of(head_r[lvl_r], wr_r));
    mem_wdata = mem_rdata;
    mem_raddr = addr_of(lvl_r, slot_of(head_r[lvl_r], rd_r));
    if (cmd.exec) begin
      mem_raddr = addr_of(top_lvl, head_r[top_lvl]);
      if (post_ok) begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(req_lvl, slot_of(head_r[req_lvl], fill_r[req_lvl]));
        mem_wdata = {task_id_r, sig_r};
      end
    end else if (rm_keep) begin
      mem_we = 1'b1;
    end
  end

  pms_ram #(
    .WIDTH (pms_pkg::MSG_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // Control state: configuration, queue pointers, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == pms_pkg::CFG_PRIORITY_MAP) begin
          map_r <= cfg_data;
        end else if (cfg_index == pms_pkg::CFG_TASK_COUNT) begin
          count_r <= cfg_data[4:0];
        end
      end
      pend_r <= cmd.remove_step && rm_issue;
      if (cmd.exec && post_ok) begin
        fill_r[req_lvl] <= fill_r[req_lvl] + FW'(1);
      end
      if (cmd.remove_step && rm_done) begin
        fill_r[lvl_r] <= wr_r;
      end
      if (cmd.capture) begin
        fill_r[lvl_r] <= fill_r[lvl_r] - FW'(1);
        head_r[lvl_r] <= (head_r[lvl_r] == HW'(QUEUE_DEPTH - 1)) ?
                         '0 : head_r[lvl_r] + HW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      task_id_r  <= in_task_id;
      sig_r      <= in_sig;
      thr_r      <= in_threshold;
    end
    if (cmd.exec) begin
      status_r  <= exec_status;
      res_tid_r <= '0;
      res_sig_r <= '0;
      res_pri_r <= '0;
      removed_r <= '0;
      rd_r      <= '0;
      wr_r      <= '0;
      lvl_r     <= go_read ? top_lvl : req_lvl;
    end
    if (cmd.remove_step) begin
      if (rm_issue) begin
        rd_r <= rd_r + FW'(1);
      end
      if (rm_keep) begin
        wr_r <= wr_r + FW'(1);
      end
      if (pend_r && rm_match) begin
        removed_r <= removed_r + FW'(1);
      end
    end
    if (cmd.capture) begin
      res_tid_r <= mem_rdata[pms_pkg::MSG_W-1:pms_pkg::SIG_W];
      res_sig_r <= mem_rdata[pms_pkg::SIG_W-1:0];
      res_pri_r <= 4'(lvl_r) + 4'd1;
    end
    if (cmd.emit) begin
      out_status_r   <= status_r;
      out_task_id_r  <= res_tid_r;
      out_sig_r      <= res_sig_r;
      out_priority_r <= res_pri_r;
      out_removed_r  <= 4'(removed_r);
      out_ready_r    <= ready_mask_c;
    end
  end

  assign sts.go_remove   = go_remove;
  assign sts.go_read     = go_read;
  assign sts.remove_done = rm_done;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_task_id       = out_task_id_r;
  assign out_sig           = out_sig_r;
  assign out_priority      = out_priority_r;
  assign out_removed_count = out_removed_r;
  assign out_ready_mask    = out_ready_r;

  // Compaction writes always land behind the read that feeds them.
  `PMS_ASSERT_IMPL(a_wr_behind_rd, clk, rst_n, cmd.remove_step && pend_r, wr_r < rd_r)
  // A dispatch pops only from a level that holds a message.
  `PMS_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, cmd.capture, fill_r[lvl_r] != '0)
  // A failed request carries no dispatched level.
  `PMS_ASSERT_IMPL(a_fail_no_level, clk, rst_n,
    out_valid_r && (out_status_r != pms_pkg::ST_OK), out_priority_r == 4'd0)
  // A successful post leaves its level ready.
  `PMS_ASSERT_NEXT(a_post_ready, clk, rst_n, cmd.exec && post_ok, fill_r[lvl_r] != '0)

endmodule

// ===== sv/priority_message_scheduler.sv =====
// A request is taken in S_IDLE, run in S_EXEC and its result issued from S_EMIT once
// the output is free; a dispatch first reads the head message in S_DREAD, and a remove
// walks the level's queue in S_REMOVE, one entry per cycle through the single read port
// of the message memory. A new request is taken only after the last result is issued.
// Reset (synchronous, rst_n low) empties all queues and zeroes both registers.
module priority_message_scheduler #(
  parameter int PRIORITY_LEVELS = pms_pkg::DEF_PRIORITY_LEVELS,
  parameter int QUEUE_DEPTH     = pms_pkg::DEF_QUEUE_DEPTH,
  parameter int TASK_SLOTS      = pms_pkg::DEF_TASK_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_task_id,
  input  logic [7:0]  in_sig,
  input  logic [3:0]  in_threshold,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_task_id,
  output logic [7:0]  out_sig,
  output logic [3:0]  out_priority,
  output logic [3:0]  out_removed_count,
  output logic [7:0]  out_ready_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  pms_pkg::cmd_t cmd;
  pms_pkg::sts_t sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pms_datapath #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .TASK_SLOTS      (TASK_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_req_type       (in_req_type),
    .in_task_id        (in_task_id),
    .in_sig            (in_sig),
    .in_threshold      (in_threshold),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_task_id       (out_task_id),
    .out_sig           (out_sig),
    .out_priority      (out_priority),
    .out_removed_count (out_removed_count),
    .out_ready_mask    (out_ready_mask)
  );

endmodule

// ===== dv/tb_priority_message_scheduler.sv =====
module tb_priority_message_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PL = pms_pkg::DEF_PRIORITY_LEVELS;
  localparam int QD = pms_pkg::DEF_QUEUE_DEPTH;
  localparam int TS = pms_pkg::DEF_TASK_SLOTS;

  localparam int HALF_PERIOD    = 5;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 40;

  // The request code that the block does not use.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0] tid;
    logic [7:0] sig;
  } msg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] tid;
    logic [7:0] sig;
    logic [3:0] thr;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] tid;
    logic [7:0] sig;
    logic [3:0] pri;
    logic [3:0] removed;
    logic [7:0] mask;
  } sched_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [3:0]  in_task_id = '0;
  logic [7:0]  in_sig = '0;
  logic [3:0]  in_threshold = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_task_id;
  logic [7:0]  out_sig;
  logic [3:0]  out_priority;
  logic [3:0]  out_removed_count;
  logic [7:0]  out_ready_mask;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  priority_message_scheduler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_task_id        (in_task_id),
    .in_sig            (in_sig),
    .in_threshold      (in_threshold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_task_id       (out_task_id),
    .out_sig           (out_sig),
    .out_priority      (out_priority),
    .out_removed_count (out_removed_count),
    .out_ready_mask    (out_ready_mask),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Scheduler state as the checker sees it.
  msg_t        msg_store [PL][QD];
  int          q_head [PL] = '{default: 0};
  int          q_fill [PL] = '{default: 0};
  logic [47:0] prio_map_q = '0;
  logic [4:0]  task_count_q = '0;

  sched_req_t  req_queue [$];
  sched_rsp_t  awaited_results [$];
  int          reqs_issued = 0;
  int          reqs_taken = 0;
  int          err_count = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        in_took = 1'b0;

  // Level index of a task, or -1 when the task id is not valid.
  function automatic int level_of(logic [3:0] tid);
    int lim;
    int lvl;
    lim = (int'(task_count_q) > TS) ? TS : int'(task_count_q);
    if (int'(tid) >= lim) return -1;
    lvl = int'(prio_map_q[3*tid +: 3]);
    if (lvl >= PL) return -1;
    return lvl;
  endfunction

  // Apply one request to the tracked queues and return the result it gives.
  function automatic sched_rsp_t schedule_request(sched_req_t r);
    sched_rsp_t rsp;
    msg_t       kept [QD];
    msg_t       m;
    int         lvl;
    int         top;
    int         n;
    int         cnt;
    rsp = '0;
    rsp.status = pms_pkg::ST_OK;
    case (r.req_type)
      pms_pkg::REQ_POST: begin
        lvl = level_of(r.tid);
        if (lvl < 0) begin
          rsp.status = pms_pkg::ST_BAD_TASK;
        end else if (q_fill[lvl] >= QD) begin
          rsp.status = pms_pkg::ST_FULL;
        end else begin
          msg_store[lvl][(q_head[lvl] + q_fill[lvl]) % QD] = '{tid: r.tid, sig: r.sig};
          q_fill[lvl]++;
        end
      end
      pms_pkg::REQ_REMOVE: begin
        lvl = level_of(r.tid);
        if (lvl < 0) begin
          rsp.status = pms_pkg::ST_BAD_TASK;
        end else begin
          // Drop every exact match and close up the survivors in order.
          n = 0;
          cnt = 0;
          for (int i = 0; i < q_fill[lvl]; i++) begin
            m = msg_store[lvl][(q_head[lvl] + i) % QD];
            if (m.tid == r.tid && m.sig == r.sig) begin
              cnt++;
            end else begin
              kept[n] = m;
              n++;
            end
          end
          for (int i = 0; i < n; i++) msg_store[lvl][(q_head[lvl] + i) % QD] = kept[i];
          q_fill[lvl] = n;
          rsp.removed = cnt[3:0];
        end
      end
      pms_pkg::REQ_DISPATCH: begin
        top = -1;
        for (int i = 0; i < PL; i++) if (q_fill[i] != 0) top = i;
        if (top < 0 || top + 1 <= int'(r.thr)) begin
          rsp.status = pms_pkg::ST_NONE;
        end else begin
          m = msg_store[top][q_head[top]];
          rsp.tid = m.tid;
          rsp.sig = m.sig;
          rsp.pri = 4'(top + 1);
          q_head[top] = (q_head[top] + 1) % QD;
          q_fill[top]--;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < PL; i++) rsp.mask[i] = (q_fill[i] != 0);
    return rsp;
  endfunction

  task automatic report(string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_result(sched_rsp_t got, sched_rsp_t want);
    if (got.status !== want.status)
      report($sformatf("status got %0d, expected %0d", got.status, want.status));
    if (got.tid !== want.tid)
      report($sformatf("task id got %0d, expected %0d", got.tid, want.tid));
    if (got.sig !== want.sig)
      report($sformatf("signal got %0d, expected %0d", got.sig, want.sig));
    if (got.pri !== want.pri)
      report($sformatf("priority got %0d, expected %0d", got.pri, want.pri));
    if (got.removed !== want.removed)
      report($sformatf("removed count got %0d, expected %0d", got.removed, want.removed));
    if (got.mask !== want.mask)
      report($sformatf("ready mask got %h, expected %h", got.mask, want.mask));
  endtask

  // Request driver: a new request goes out only once the previous one was taken.
  always @(negedge clk) begin : drv
    sched_req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = req_queue.pop_front();
        in_req_type  <= cur.req_type;
        in_task_id   <= cur.tid;
        in_sig       <= cur.sig;
        in_threshold <= cur.thr;
        in_valid     <= 1'b1;
        reqs_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Monitor: tracks register writes, predicts accepted requests, checks results.
  always @(posedge clk) begin : mon
    sched_rsp_t got;
    logic       any_taken;
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took <= in_valid && !in_stall;
      any_taken = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pms_pkg::CFG_PRIORITY_MAP: prio_map_q = cfg_data;
          pms_pkg::CFG_TASK_COUNT:   task_count_q = cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        got.status  = out_status;
        got.tid     = out_task_id;
        got.sig     = out_sig;
        got.pri     = out_priority;
        got.removed = out_removed_count;
        got.mask    = out_ready_mask;
        if (awaited_results.size() == 0) report("result with no request outstanding");
        else compare_result(got, awaited_results.pop_front());
      end

      if (in_valid && !in_stall) begin
        awaited_results.push_back(schedule_request('{in_req_type, in_task_id,
                                                     in_sig, in_threshold}));
        reqs_taken++;
      end

      // Watchdog on cycles with no handshake at all.
      if (any_taken) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_request(logic [1:0] req_type, logic [3:0] tid, logic [7:0] sig,
                               logic [3:0] thr);
    req_queue.push_back('{req_type, tid, sig, thr});
  endtask

  // Wait, on falling edges, until every request was taken and answered.
  task automatic wait_drained();
    while (!(req_queue.size() == 0 && reqs_issued == reqs_taken &&
             awaited_results.size() == 0))
      @(negedge clk);
  endtask

  // Called on a falling edge; leaves valid high for a following write.
  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(logic [47:0] map, logic [4:0] count);
    write_reg(pms_pkg::CFG_PRIORITY_MAP, map);
    write_reg(pms_pkg::CFG_TASK_COUNT, {43'd0, count});
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly valid tasks and a few signals so removes find matches.
  task automatic queue_random(int n, logic [4:0] count);
    int tid_hi;
    int pick;
    logic [1:0] rt;
    logic [3:0] tid;
    logic [7:0] sig;
    logic [3:0] thr;
    tid_hi = (count == 0) ? 0 : ((count > TS) ? TS - 1 : int'(count) - 1);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 3) rt = REQ_UNUSED;
      else if (pick < 48) rt = pms_pkg::REQ_POST;
      else if (pick < 63) rt = pms_pkg::REQ_REMOVE;
      else rt = pms_pkg::REQ_DISPATCH;
      tid = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(tid_hi));
      sig = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      if ($urandom_range(9) == 0) thr = 4'($urandom_range(15));
      else if ($urandom_range(1) == 0) thr = 4'd0;
      else thr = 4'($urandom_range(PL));
      queue_request(rt, tid, sig, thr);
    end
  endtask

  task automatic run_phase(logic [47:0] map, logic [4:0] count, int n, int pct);
    wait_drained();
    set_config(map, count);
    idle_pct  = pct;
    stall_pct = pct;
    queue_random(n, count);
  endtask

  initial begin : stim
    logic [47:0] ladder_map;
    ladder_map = '0;
    for (int t = 0; t < TS; t++) ladder_map[3*t +: 3] = t[2:0];

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No valid tasks: every post and remove is rejected.
    set_config(48'h0, 5'd0);
    queue_request(pms_pkg::REQ_POST, 4'd0, 8'h01, 4'd0);
    queue_request(pms_pkg::REQ_REMOVE, 4'd0, 8'h01, 4'd0);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd0);
    queue_request(REQ_UNUSED, 4'd15, 8'hFF, 4'd15);
    wait_drained();

    // Task t lives on level t mod 8.
    set_config(ladder_map, 5'd16);
    queue_request(pms_pkg::REQ_POST, 4'd0, 8'h00, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd15, 8'hFF, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd7, 8'h5A, 4'd0);
    // Thresholds at or above the top priority never dispatch.
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd15);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd8);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd7);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd0);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd1);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd0);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd0);
    // Remove on an empty level.
    queue_request(pms_pkg::REQ_REMOVE, 4'd3, 8'h11, 4'd0);
    // Tasks 3 and 11 share a level: fill it, then overflow it.
    queue_request(pms_pkg::REQ_POST, 4'd3, 8'h11, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd11, 8'h11, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd3, 8'h22, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd3, 8'h11, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd11, 8'h22, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd3, 8'h11, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd3, 8'h22, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd11, 8'h11, 4'd0);
    queue_request(pms_pkg::REQ_POST, 4'd3, 8'h33, 4'd0);
    // Removal must match task and signal and keep the rest in order.
    queue_request(pms_pkg::REQ_REMOVE, 4'd3, 8'h11, 4'd0);
    queue_request(pms_pkg::REQ_DISPATCH, 4'd0, 8'h00, 4'd0);
    queue_request(pms_pkg::REQ_REMOVE, 4'd11, 8'h11, 4'd0);
    queue_request(REQ_UNUSED, 4'd3, 8'h22, 4'd3);

    // Random phases; the first runs with no idling on either side.
    run_phase(48'({$urandom, $urandom}), 5'd16, 120, 0);
    run_phase(48'({$urandom, $urandom}), 5'd16, 200, 8);
    run_phase(48'h0, 5'd31, 150, 8);
    run_phase(48'hFFFF_FFFF_FFFF, 5'($urandom_range(15, 1)), 120, 8);
    run_phase(48'({$urandom, $urandom}), 5'd0, 20, 8);
    run_phase(48'({$urandom, $urandom}), 5'($urandom_range(31)), 100, 8);

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pms_pkg.sv
sv/pms_ram.sv
sv/pms_ctrl.sv
sv/pms_datapath.sv
sv/priority_message_scheduler.sv
dv/tb_priority_message_scheduler.sv
